/* hw/rtl/llw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llw_pkg: shared types and constants for the link-loss watchdog
// Holds the field widths, the register reset values, the register indexes and
// the structs that move between the watchdog's modules.
// ----------------------------------------------------------------------------
package llw_pkg;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int CHECK_W = 16;
    localparam int DROPS_W = 16;
    localparam int IDX_W   = 2;

    // Register reset values.
    localparam logic [CHECK_W-1:0] CHECK_INTERVAL_RST = 16'd2000;
    localparam logic [TIME_W-1:0]  KICK_INTERVAL_RST  = 32'd180000;
    localparam logic [TIME_W-1:0]  REBOOT_AFTER_RST   = 32'd1800000;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_CHECK_INTERVAL = 2'd0;
    localparam logic [IDX_W-1:0] REG_KICK_INTERVAL  = 2'd1;
    localparam logic [IDX_W-1:0] REG_REBOOT_AFTER   = 2'd2;

    // Saturation point of the drop counter.
    localparam logic [DROPS_W-1:0] DROPS_MAX = {DROPS_W{1'b1}};

    // Current register settings.
    typedef struct packed {
        logic [CHECK_W-1:0] check_interval_ms;
        logic [TIME_W-1:0]  kick_interval_ms;
        logic [TIME_W-1:0]  reboot_after_ms;
    } t_cfg;

    // One time sample.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              update_busy;
        logic              helper_active;
    } t_sample;

    // One result beat.
    typedef struct packed {
        logic               checked;
        logic               went_down;
        logic               recovered;
        logic               kick;
        logic               reboot;
        logic               is_down;
        logic [TIME_W-1:0]  offline_ms;
        logic [DROPS_W-1:0] drops;
        logic [TIME_W-1:0]  last_outage_ms;
        logic [TIME_W-1:0]  since_outage_end_ms;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/llw_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llw_cfg_regs: watchdog configuration registers
// Holds the check interval, kick interval and reboot threshold, written through
// a plain write port. Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module llw_cfg_regs
    import llw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_wdata,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHECK_INTERVAL: n_cfg.check_interval_ms = i_cfg_wdata[CHECK_W-1:0];
                REG_KICK_INTERVAL:  n_cfg.kick_interval_ms  = i_cfg_wdata;
                REG_REBOOT_AFTER:   n_cfg.reboot_after_ms   = i_cfg_wdata;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_interval_ms <= CHECK_INTERVAL_RST;
            r_cfg.kick_interval_ms  <= KICK_INTERVAL_RST;
            r_cfg.reboot_after_ms   <= REBOOT_AFTER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* hw/rtl/llw_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llw_core: watchdog state and decision logic
// Holds the outage state and, for the sample in the input register, works out
// the check, the kick and reboot pulses and the statistics in one pass. The
// state advances on the cycle the result is handed to the output register.
// ----------------------------------------------------------------------------
module llw_core
    import llw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_sample i_sample,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    // Outage state.
    logic               r_down_flag,        n_down_flag;
    logic [TIME_W-1:0]  r_down_since,       n_down_since;
    logic [TIME_W-1:0]  r_last_kick,        n_last_kick;
    logic [TIME_W-1:0]  r_last_check,       n_last_check;
    logic [DROPS_W-1:0] r_drop_total,       n_drop_total;
    logic [TIME_W-1:0]  r_outage_length,    n_outage_length;
    logic [TIME_W-1:0]  r_outage_end,       n_outage_end;
    logic               r_outage_end_valid, n_outage_end_valid;

    // Wrapping time differences against the stored stamps.
    logic [TIME_W-1:0] since_check;
    logic [TIME_W-1:0] since_down;
    logic [TIME_W-1:0] since_kick;
    logic [TIME_W-1:0] since_end;

    assign since_check = i_sample.now_ms - r_last_check;
    assign since_down  = i_sample.now_ms - r_down_since;
    assign since_kick  = i_sample.now_ms - r_last_kick;
    assign since_end   = i_sample.now_ms - r_outage_end;

    // Check and outage decisions.
    always_comb begin
        n_down_flag        = r_down_flag;
        n_down_since       = r_down_since;
        n_last_kick        = r_last_kick;
        n_last_check       = r_last_check;
        n_drop_total       = r_drop_total;
        n_outage_length    = r_outage_length;
        n_outage_end       = r_outage_end;
        n_outage_end_valid = r_outage_end_valid;
        o_result           = '0;

        if (since_check >= {{(TIME_W-CHECK_W){1'b0}}, i_cfg.check_interval_ms}) begin
            o_result.checked = 1'b1;
            n_last_check     = i_sample.now_ms;
            if (i_sample.link_up) begin
                if (r_down_flag) begin
                    // The outage ends here.
                    o_result.recovered = 1'b1;
                    n_down_flag        = 1'b0;
                    n_outage_length    = since_down;
                    n_outage_end       = i_sample.now_ms;
                    n_outage_end_valid = 1'b1;
                end
            end else if (!r_down_flag) begin
                // A new outage starts here.
                o_result.went_down = 1'b1;
                n_down_flag        = 1'b1;
                n_down_since       = i_sample.now_ms;
                n_last_kick        = i_sample.now_ms;
                if (r_drop_total != DROPS_MAX) begin
                    n_drop_total = r_drop_total + 1'b1;
                end
            end else if (!i_sample.update_busy) begin
                // Still down: reboot takes priority over the kick.
                if (since_down >= i_cfg.reboot_after_ms && !i_sample.helper_active) begin
                    o_result.reboot = 1'b1;
                end else if (since_kick >= i_cfg.kick_interval_ms) begin
                    o_result.kick = 1'b1;
                    n_last_kick   = i_sample.now_ms;
                end
            end
        end

        // Statistics after this step. A fresh outage start or end reads as zero.
        o_result.is_down = n_down_flag;
        if (n_down_flag && !o_result.went_down) begin
            o_result.offline_ms = since_down;
        end
        o_result.drops          = n_drop_total;
        o_result.last_outage_ms = n_outage_length;
        if (n_outage_end_valid && !o_result.recovered) begin
            o_result.since_outage_end_ms = since_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_flag        <= 1'b0;
            r_down_since       <= '0;
            r_last_kick        <= '0;
            r_last_check       <= '0;
            r_drop_total       <= '0;
            r_outage_length    <= '0;
            r_outage_end       <= '0;
            r_outage_end_valid <= 1'b0;
        end else if (i_fire) begin
            r_down_flag        <= n_down_flag;
            r_down_since       <= n_down_since;
            r_last_kick        <= n_last_kick;
            r_last_check       <= n_last_check;
            r_drop_total       <= n_drop_total;
            r_outage_length    <= n_outage_length;
            r_outage_end       <= n_outage_end;
            r_outage_end_valid <= n_outage_end_valid;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/link_loss_watchdog_unit.sv */
`default_nettype none
// Path: an accepted sample is held in the input register, and its result beat
// moves on to the result register once that register is free.
// Throughput: one sample per cycle while the result channel is not stalled;
// the outage state is read and updated in a single pass between the two registers.
// Reset: synchronous, active low; clears the outage state and statistics and
// loads the register defaults (2000, 180000, 1800000 ms).
// ----------------------------------------------------------------------------
// link_loss_watchdog_unit: link-loss watchdog, top level
// Takes millisecond time samples with link and status flags, checks the link
// at the check interval, and issues reconnect kicks and reboot requests
// during long outages while reporting outage statistics on every beat.
// ----------------------------------------------------------------------------
module link_loss_watchdog_unit
    import llw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [TIME_W-1:0]  i_cfg_wdata,
    // Sample channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic               i_link_up,
    input  wire logic               i_update_busy,
    input  wire logic               i_helper_active,
    // Result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_checked,
    output logic                    o_went_down,
    output logic                    o_recovered,
    output logic                    o_kick,
    output logic                    o_reboot,
    output logic                    o_is_down,
    output logic [TIME_W-1:0]       o_offline_ms,
    output logic [DROPS_W-1:0]      o_drops,
    output logic [TIME_W-1:0]       o_last_outage_ms,
    output logic [TIME_W-1:0]       o_since_outage_end_ms
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    fire;

    // Stage handshakes: a beat moves on when the result register is free.
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || fire;

    llw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    llw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.now_ms        <= i_now_ms;
            r_in.link_up       <= i_link_up;
            r_in.update_busy   <= i_update_busy;
            r_in.helper_active <= i_helper_active;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_checked             = r_out.checked;
    assign o_went_down           = r_out.went_down;
    assign o_recovered           = r_out.recovered;
    assign o_kick                = r_out.kick;
    assign o_reboot              = r_out.reboot;
    assign o_is_down             = r_out.is_down;
    assign o_offline_ms          = r_out.offline_ms;
    assign o_drops               = r_out.drops;
    assign o_last_outage_ms      = r_out.last_outage_ms;
    assign o_since_outage_end_ms = r_out.since_outage_end_ms;

endmodule
`default_nettype wire
